### rtl/sfd_pkg.sv
// Shared types, constants and the rounding/saturation helper of the stereo
// feedback delay. No dependencies; every other file of the block uses it.
package sfd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int PROD_W   = 42;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TIME     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY      = 8'd3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

  localparam logic signed [SAMPLE_W-1:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S24_MIN = 24'sh800000;

  // Output buffer depth and the number of lane stages ahead of it.
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int PIPE_INFLIGHT  = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_t;

  // Registered mix products of one lane, handed to the merge stage.
  typedef struct packed {
    logic                     valid;
    logic signed [PROD_W-1:0] dry;
    logic signed [PROD_W-1:0] wet;
  } lane_out_t;

  // Q0.16 scaling: round to nearest with ties upward, then clamp to 24 bits.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] t;
    logic signed [25:0] q;
    logic signed [SAMPLE_W-1:0] r;
    t = v + 42'sd32768;
    q = t[PROD_W-1:16];
    if (q[25:23] == 3'b000 || q[25:23] == 3'b111) begin
      r = q[SAMPLE_W-1:0];
    end else if (q[25]) begin
      r = S24_MIN;
    end else begin
      r = S24_MAX;
    end
    return r;
  endfunction

endpackage

### rtl/stereo_feedback_delay.sv
// Top level of the stereo feedback delay: configuration registers, input
// handshake, two sfd_lane instances and the sfd_merge stage. Uses sfd_pkg.
//
//  channel | signals                         | payload
//  --------+---------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data     | sfd_pkg::in_t (left, right)
//  result  | out_valid, out_ready, out_data  | sfd_pkg::out_t (left, right)
//  config  | cfg_valid, cfg_ready, cfg_index | cfg_data, 16-bit register value
//
// One frame is accepted per cycle while in_ready is high. The line read and then
// the feedback/mix multiply in each lane are registered; the merge sum is formed as
// the frame enters the output buffer, and out_valid for it rises from there.
// The feedback recurrence closes within the multiply stage, so back-to-back reads
// of one entry are forwarded. No clearing pass after reset: a fill count per line
// makes unwritten entries read as zero. Result stalls are absorbed by a four-frame
// output buffer; in_ready drops once it holds two frames, as two more may be in flight.
module stereo_feedback_delay #(
  parameter int LEFT_LINE_DEPTH  = 65536,
  parameter int RIGHT_LINE_DEPTH = 55706
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sfd_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sfd_pkg::out_t                        out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfd_pkg::GAIN_W-1:0]           cfg_data
);

  localparam int PW = $clog2(sfd_pkg::OUT_FIFO_DEPTH + 1);

  logic [sfd_pkg::GAIN_W-1:0] fb_r, wet_r, dry_r;
  logic in_acc, cfg_acc, time_wr, room;
  sfd_pkg::lane_out_t left_lane, right_lane;
  logic [PW-1:0] pending_r;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign time_wr   = cfg_acc && (cfg_index == sfd_pkg::REG_TIME);
  assign in_ready  = room;
  assign in_acc    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r  <= sfd_pkg::GAIN_RESET;
      wet_r <= sfd_pkg::GAIN_RESET;
      dry_r <= sfd_pkg::GAIN_RESET;
    end else if (cfg_acc) begin
      case (cfg_index)
        sfd_pkg::REG_FEEDBACK: fb_r  <= cfg_data;
        sfd_pkg::REG_WET:      wet_r <= cfg_data;
        sfd_pkg::REG_DRY:      dry_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfd_lane #(.DEPTH(LEFT_LINE_DEPTH)) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .sample   (in_data.left_in),
    .time_wr  (time_wr),
    .time_val (cfg_data),
    .fb_gain  (fb_r),
    .wet_gain (wet_r),
    .dry_gain (dry_r),
    .lane_out (left_lane)
  );

  sfd_lane #(.DEPTH(RIGHT_LINE_DEPTH)) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_acc),
    .sample   (in_data.right_in),
    .time_wr  (time_wr),
    .time_val (cfg_data),
    .fb_gain  (fb_r),
    .wet_gain (wet_r),
    .dry_gain (dry_r),
    .lane_out (right_lane)
  );

  sfd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .left_lane  (left_lane),
    .right_lane (right_lane),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Frames accepted and not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !(out_valid && out_ready)) begin
      pending_r <= pending_r + 1'b1;
    end else if (!in_acc && out_valid && out_ready) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= PW'(sfd_pkg::OUT_FIFO_DEPTH))
    else $error("more frames in flight than the output buffer holds");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> pending_r < PW'(sfd_pkg::OUT_FIFO_DEPTH))
    else $error("input ready although no buffer room is left");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result offered with no frame outstanding");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    left_lane.valid == right_lane.valid)
    else $error("lane pipelines out of step");

endmodule

### rtl/sfd_lane.sv
// One channel of the delay: circular line memory, position and fill tracking,
// feedback write-back and the registered wet/dry products. Uses sfd_pkg.
module sfd_lane #(
  parameter int DEPTH = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                time_wr,
  input  logic [sfd_pkg::GAIN_W-1:0]          time_val,
  input  logic [sfd_pkg::GAIN_W-1:0]          fb_gain,
  input  logic [sfd_pkg::GAIN_W-1:0]          wet_gain,
  input  logic [sfd_pkg::GAIN_W-1:0]          dry_gain,
  output sfd_pkg::lane_out_t                  lane_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int DW = $clog2(DEPTH + 1);
  localparam logic [DW+15:0] DEPTH_V = (DW + 16)'(DEPTH);
  localparam logic [AW-1:0]  LIM_RST = AW'(DEPTH / 2);

  logic [sfd_pkg::SAMPLE_W-1:0] mem [DEPTH];

  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] limit_r;
  logic [AW-1:0] fill_r;
  logic          zero_wr_r;
  logic          ok_nxt;
  logic [DW+15:0] lim_prod;

  logic                                s1_v_r;
  logic [AW-1:0]                       s1_addr_r;
  logic signed [sfd_pkg::SAMPLE_W-1:0] s1_in_r;
  logic                                s1_ok_r;
  logic signed [sfd_pkg::SAMPLE_W-1:0] rd_r;

  logic                                wr_v_r;
  logic [AW-1:0]                       wr_addr_r;
  logic signed [sfd_pkg::SAMPLE_W-1:0] wr_data_r;

  logic                                s2_v_r;
  logic signed [sfd_pkg::PROD_W-1:0]   dry_r, wet_r;

  logic signed [sfd_pkg::SAMPLE_W-1:0] stored;
  logic signed [sfd_pkg::SAMPLE_W:0]   fb_sum;
  logic signed [sfd_pkg::PROD_W-1:0]   fb_prod, dry_p, wet_p;
  logic signed [sfd_pkg::SAMPLE_W-1:0] fb_val;

  assign lim_prod = DEPTH_V * {{DW{1'b0}}, time_val};

  // Entry 1 is the first one ever written, so addresses 1..fill_r hold data;
  // address 0 is tracked by its own flag.
  always_comb begin
    if (pos_r >= limit_r) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
    if (pos_nxt == '0) begin
      ok_nxt = zero_wr_r;
    end else begin
      ok_nxt = (pos_nxt <= fill_r);
    end
  end

  // The write at the edge of this item's read is not yet visible in rd_r.
  always_comb begin
    if (wr_v_r && wr_addr_r == s1_addr_r) begin
      stored = wr_data_r;
    end else if (s1_ok_r) begin
      stored = rd_r;
    end else begin
      stored = '0;
    end
    fb_sum  = {stored[sfd_pkg::SAMPLE_W-1], stored} + {s1_in_r[sfd_pkg::SAMPLE_W-1], s1_in_r};
    fb_prod = fb_sum * $signed({1'b0, fb_gain});
    fb_val  = sfd_pkg::round_sat(fb_prod);
    dry_p   = s1_in_r * $signed({1'b0, dry_gain});
    wet_p   = stored * $signed({1'b0, wet_gain});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      limit_r   <= LIM_RST;
      fill_r    <= '0;
      zero_wr_r <= 1'b0;
      s1_v_r    <= 1'b0;
      wr_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      if (time_wr) begin
        limit_r <= lim_prod[AW+15:16];
      end
      if (accept) begin
        pos_r <= pos_nxt;
        if (pos_nxt == '0) begin
          zero_wr_r <= 1'b1;
        end else if (pos_nxt > fill_r) begin
          fill_r <= pos_nxt;
        end
      end
      s1_v_r <= accept;
      wr_v_r <= s1_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r      <= mem[pos_nxt];
      s1_addr_r <= pos_nxt;
      s1_in_r   <= sample;
      s1_ok_r   <= ok_nxt;
    end
    if (s1_v_r) begin
      mem[s1_addr_r] <= fb_val;
      wr_addr_r      <= s1_addr_r;
      wr_data_r      <= fb_val;
      dry_r          <= dry_p;
      wet_r          <= wet_p;
    end
  end

  assign lane_out.valid = s2_v_r;
  assign lane_out.dry   = dry_r;
  assign lane_out.wet   = wet_r;

endmodule

### rtl/sfd_merge.sv
// Merge stage: sums and saturates both lanes' products into one stereo frame
// and buffers frames for the result channel. Uses sfd_pkg.
module sfd_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  sfd_pkg::lane_out_t left_lane,
  input  sfd_pkg::lane_out_t right_lane,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output sfd_pkg::out_t      out_data
);

  localparam int FD = sfd_pkg::OUT_FIFO_DEPTH;
  localparam int FA = $clog2(FD);
  localparam int CW = $clog2(FD + 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(FD - sfd_pkg::PIPE_INFLIGHT);

  sfd_pkg::out_t fifo [FD];
  logic [FA-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r;
  logic          push, pop;
  sfd_pkg::out_t frame;

  always_comb begin
    frame.left_out  = sfd_pkg::round_sat(left_lane.dry + left_lane.wet);
    frame.right_out = sfd_pkg::round_sat(right_lane.dry + right_lane.wet);
  end

  assign push      = left_lane.valid & right_lane.valid;
  assign out_valid = (count_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = fifo[rp_r];
  // A new frame is taken only when the buffer can hold everything in flight.
  assign room      = (count_r < ROOM_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp_r] <= frame;
    end
  end

endmodule
